// ----- src/pkh_pkg.sv -----
package pkh_pkg;

   // Command codes carried in a request transaction.
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   // Status codes returned in a response transaction.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_DUP  = 2'd2;
   localparam logic [1:0] ST_MISS = 2'd3;

   // Multipliers of the key mixer.
   localparam logic [31:0] MIX_C1 = 32'h7feb352d;
   localparam logic [31:0] MIX_C2 = 32'h846ca68b;

   localparam int LIMIT_W = 9;
   localparam int ROW_OUT_W = 8;
   localparam int LIVE_W = 9;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [ROW_OUT_W-1:0] row;
      logic [LIVE_W-1:0]    live_count;
   } rsp_type;

   // A classified command waiting between the front and the back.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] key;
      logic [31:0] hash;
   } job_type;

endpackage

// ----- src/pkh_ram.sv -----
module pkh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/pkh_front.sv -----
module pkh_front
   import pkh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   input  logic    hold,
   output logic    job_push,
   output job_type job_item,
   input  logic    job_full
);

   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff, s2_valid_in;
   logic [1:0]  s1_cmd_ff, s2_cmd_ff;
   logic [31:0] s1_key_ff, s2_key_ff;
   logic [31:0] s1_mix_ff, s2_mix_ff;
   logic [31:0] fold0, fold1;
   logic        advance;
   logic        take;

   // The pipe moves as a whole unless its last stage cannot leave.
   assign advance   = !s2_valid_ff || !job_full;
   assign req_stall = !advance || hold;
   assign take      = req_valid && !req_stall;

   // First and second mixing rounds, a multiply in each stage.
   assign fold0 = req_payload.key ^ (req_payload.key >> 16);
   assign fold1 = s1_mix_ff ^ (s1_mix_ff >> 15);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      if (advance) begin
         s1_valid_in = take;
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (advance) begin
         s1_cmd_ff <= req_payload.cmd;
         s1_key_ff <= req_payload.key;
         s1_mix_ff <= 32'(fold0 * MIX_C1);
         s2_cmd_ff <= s1_cmd_ff;
         s2_key_ff <= s1_key_ff;
         s2_mix_ff <= 32'(fold1 * MIX_C2);
      end
   end

   // Final fold and hand-over to the queue.
   assign job_push      = s2_valid_ff && !job_full;
   assign job_item.cmd  = s2_cmd_ff;
   assign job_item.key  = s2_key_ff;
   assign job_item.hash = s2_mix_ff ^ (s2_mix_ff >> 16);

endmodule

// ----- src/pkh_queue.sv -----
module pkh_queue
   import pkh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_item,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_item
);

   localparam int DEPTH = 2;

   job_type    entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full       = (fill_ff == 2'(DEPTH));
   assign head_valid = (fill_ff != 2'd0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- src/pkh_back.sv -----
module pkh_back
   import pkh_pkg::*;
#(
   parameter int ROWS = 256,
   parameter int SLOTS = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [LIMIT_W-1:0] row_limit,
   input  logic               job_valid,
   input  job_type            job_item,
   output logic               job_pop,
   output logic               clearing,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_payload
);

   localparam int ROW_W  = $clog2(ROWS);
   localparam int CNT_W  = $clog2(ROWS + 1);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int ENT_W  = CNT_W + 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SWEEP, S_PROBE, S_SLOT, S_KEY, S_MISS, S_POPW, S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [31:0]        key_ff, key_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0]  steps_ff, steps_in;
   logic               ffv_ff, ffv_in;
   logic [SLOT_W-1:0]  ffi_ff, ffi_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               reply_ff, reply_in;
   logic [CNT_W-1:0]   fresh_ff, fresh_in;
   logic [CNT_W-1:0]   depth_ff, depth_in;
   logic [1:0]         res_st_ff, res_st_in;
   logic [ROW_W-1:0]   res_row_ff, res_row_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               slot_we;
   logic [SLOT_W-1:0]  slot_waddr;
   logic [ENT_W-1:0]   slot_wdata;
   logic [ENT_W-1:0]   slot_rdata;
   logic               key_we;
   logic [ROW_W-1:0]   key_waddr;
   logic [ROW_W-1:0]   key_raddr;
   logic [31:0]        key_rdata;
   logic               free_we;
   logic [ROW_W-1:0]   free_raddr;
   logic [ROW_W-1:0]   free_rdata;
   logic               slot_tomb;
   logic [CNT_W-1:0]   slot_ref;
   logic               can_fresh;
   logic               out_free;

   // Slot entries hold a tombstone bit and the row plus one.
   pkh_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_slot_ram (
      .clock(clock), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
      .raddr(idx_ff), .rdata(slot_rdata)
   );

   pkh_ram #(.WIDTH(32), .DEPTH(ROWS)) u_key_ram (
      .clock(clock), .we(key_we), .waddr(key_waddr), .wdata(key_ff),
      .raddr(key_raddr), .rdata(key_rdata)
   );

   pkh_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_free_ram (
      .clock(clock), .we(free_we), .waddr(depth_ff[ROW_W-1:0]), .wdata(row_ff),
      .raddr(free_raddr), .rdata(free_rdata)
   );

   assign slot_tomb  = slot_rdata[CNT_W];
   assign slot_ref   = slot_rdata[CNT_W-1:0];
   assign key_raddr  = ROW_W'(slot_ref - CNT_W'(1));
   assign free_raddr = ROW_W'(depth_ff - CNT_W'(1));
   assign can_fresh  = (32'(fresh_ff) < 32'(row_limit)) && (32'(fresh_ff) < ROWS);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign clearing   = (state_ff == S_SWEEP);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      steps_in     = steps_ff;
      ffv_in       = ffv_ff;
      ffi_in       = ffi_ff;
      row_in       = row_ff;
      reply_in     = reply_ff;
      fresh_in     = fresh_ff;
      depth_in     = depth_ff;
      res_st_in    = res_st_ff;
      res_row_in   = res_row_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      slot_we      = 1'b0;
      slot_waddr   = idx_ff;
      slot_wdata   = '0;
      key_we       = 1'b0;
      key_waddr    = fresh_ff[ROW_W-1:0];
      free_we      = 1'b0;
      job_pop      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               cmd_in   = job_item.cmd;
               key_in   = job_item.key;
               idx_in   = job_item.hash[SLOT_W-1:0];
               steps_in = '0;
               ffv_in   = 1'b0;
               if (job_item.cmd == CMD_CLEAR) begin
                  idx_in   = '0;
                  reply_in = 1'b1;
                  state_in = S_SWEEP;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         // Clearing pass: one slot per cycle.
         S_SWEEP: begin
            slot_we = 1'b1;
            idx_in  = idx_ff + SLOT_W'(1);
            if (idx_ff == LAST_SLOT) begin
               fresh_in   = '0;
               depth_in   = '0;
               res_st_in  = ST_OK;
               res_row_in = '0;
               state_in   = reply_ff ? S_EMIT : S_IDLE;
            end
         end
         S_PROBE: begin
            state_in = S_SLOT;
         end
         // Classify the slot just read.
         S_SLOT: begin
            if (slot_ref == '0) begin
               if (!ffv_ff) begin
                  ffv_in = 1'b1;
                  ffi_in = idx_ff;
               end
               if (!slot_tomb || steps_ff == LAST_SLOT) begin
                  state_in = S_MISS;
               end else begin
                  idx_in   = idx_ff + SLOT_W'(1);
                  steps_in = steps_ff + SLOT_W'(1);
                  state_in = S_PROBE;
               end
            end else begin
               row_in   = key_raddr;
               state_in = S_KEY;
            end
         end
         // Compare the stored key of the slot's row.
         S_KEY: begin
            if (key_rdata == key_ff) begin
               res_st_in  = ST_OK;
               res_row_in = row_ff;
               state_in   = S_EMIT;
               if (cmd_ff == CMD_INSERT) begin
                  res_st_in  = ST_DUP;
                  res_row_in = '0;
               end else if (cmd_ff == CMD_DELETE) begin
                  slot_we    = 1'b1;
                  slot_wdata = {1'b1, CNT_W'(0)};
                  if (32'(depth_ff) < ROWS) begin
                     free_we  = 1'b1;
                     depth_in = depth_ff + CNT_W'(1);
                  end
               end
            end else if (steps_ff == LAST_SLOT) begin
               state_in = S_MISS;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               steps_in = steps_ff + SLOT_W'(1);
               state_in = S_PROBE;
            end
         end
         // Key absent: answer, or allocate a row for an insert.
         S_MISS: begin
            res_row_in = '0;
            state_in   = S_EMIT;
            if (cmd_ff != CMD_INSERT) begin
               res_st_in = ST_MISS;
            end else if ((!can_fresh && depth_ff == '0) || !ffv_ff) begin
               res_st_in = ST_FULL;
            end else if (can_fresh) begin
               key_we     = 1'b1;
               slot_we    = 1'b1;
               slot_waddr = ffi_ff;
               slot_wdata = {1'b0, fresh_ff + CNT_W'(1)};
               fresh_in   = fresh_ff + CNT_W'(1);
               res_st_in  = ST_OK;
               res_row_in = fresh_ff[ROW_W-1:0];
            end else begin
               depth_in = depth_ff - CNT_W'(1);
               state_in = S_POPW;
            end
         end
         // Reuse the row taken from the free stack.
         S_POPW: begin
            key_we     = 1'b1;
            key_waddr  = free_rdata;
            slot_we    = 1'b1;
            slot_waddr = ffi_ff;
            slot_wdata = {1'b0, CNT_W'(free_rdata) + CNT_W'(1)};
            res_st_in  = ST_OK;
            res_row_in = free_rdata;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = res_st_ff;
               rsp_data_in.row         = ROW_OUT_W'(res_row_ff);
               rsp_data_in.live_count  = LIVE_W'(fresh_ff - depth_ff);
               state_in                = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         idx_ff       <= '0;
         reply_ff     <= 1'b0;
         fresh_ff     <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         reply_ff     <= reply_in;
         fresh_ff     <= fresh_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      steps_ff    <= steps_in;
      ffv_ff      <= ffv_in;
      ffi_ff      <= ffi_in;
      row_ff      <= row_in;
      res_st_ff   <= res_st_in;
      res_row_ff  <= res_row_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef SYNTHESIS
   a_depth_le_fresh: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= fresh_ff) else $error("free stack deeper than rows handed out");
   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fresh_ff) <= ROWS) else $error("fresh row count beyond row store");
   a_sweep_writes: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWEEP |-> slot_we && slot_wdata == '0)
      else $error("clearing pass did not clear a slot");
   a_row_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.status == ST_OK || rsp_data_ff.row == '0))
      else $error("row not zero on a failed transaction");
`endif

endmodule

// ----- src/primary_key_hash_table_top.sv -----
// Keyed row table with a hashed, linearly probed slot index.
// Request channel (req_valid, req_stall, req_payload): one transaction per
// command, insert, find, delete or clear, with a signed 32-bit key.
// Response channel (rsp_valid, rsp_stall, rsp_payload): exactly one
// transaction per command, in order: status, row and live-row count.
// csr_we/csr_wdata write the row limit (reset value 256).
// A command is hashed in the front; the back end then dequeues it, reads
// each slot visited and, for a live slot only, the key of its row (slot
// read, then key read, through the registered slot and key memory read
// ports), decides a miss or an insert, reuses a freed row when one is
// needed, and loads the response.
// Clear, and reset, run a pass over all SLOTS slots, one a cycle; after
// reset no request is taken until that pass is done.
// A two-entry queue parts the hashing front from the back end, and the
// response sits in an output register, so the front keeps taking requests
// while a response waits. When the receiver stalls, the response holds and
// the back end waits; the front then stalls once its queue is full.
module primary_key_hash_table_top
   import pkh_pkg::*;
#(
   parameter int ROWS = 256,
   parameter int SLOTS = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_payload,
   input  logic               csr_we,
   input  logic [LIMIT_W-1:0] csr_wdata
);

   logic [LIMIT_W-1:0] row_limit_ff, row_limit_in;
   logic               job_push, job_full, job_pop, job_valid, clearing;
   job_type            job_in, job_head;

   // Row limit register.
   assign row_limit_in = csr_we ? csr_wdata : row_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_limit_ff <= LIMIT_W'(256);
      end else begin
         row_limit_ff <= row_limit_in;
      end
   end

   pkh_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .hold(clearing), .job_push(job_push), .job_item(job_in), .job_full(job_full)
   );

   pkh_queue u_queue (
      .clock(clock), .reset(reset),
      .push(job_push), .push_item(job_in), .full(job_full),
      .pop(job_pop), .head_valid(job_valid), .head_item(job_head)
   );

   pkh_back #(.ROWS(ROWS), .SLOTS(SLOTS)) u_back (
      .clock(clock), .reset(reset), .row_limit(row_limit_ff),
      .job_valid(job_valid), .job_item(job_head), .job_pop(job_pop),
      .clearing(clearing),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

endmodule
